@@ hdl/source_blocklist_packet_filter_core_macros.svh @@
// Assertion macros used by the top level of the blocklist filter RTL.
`ifndef SOURCE_BLOCKLIST_PACKET_FILTER_CORE_MACROS_SVH
`define SOURCE_BLOCKLIST_PACKET_FILTER_CORE_MACROS_SVH
`ifndef ASSERT_OFF
`define SBF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define SBF_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define SBF_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SBF_ASSERT(lbl, prop, msg)
`define SBF_ASSERT_IMP(lbl, ante, cons, msg)
`define SBF_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

@@ hdl/sbf_pkg.sv @@
// Types and constants shared by the blocklist filter modules.
package sbf_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int ADDR_W      = 32;
    localparam int PORT_W      = 16;
    localparam int PROTO_W     = 8;
    localparam int COUNT_W     = 64;
    localparam int ENTRIES_W   = 7;

    localparam logic [PORT_W-1:0]  API_PORT_RESET = 16'd8420;
    localparam logic [PROTO_W-1:0] PROTO_TCP      = 8'd6;
    localparam logic [PROTO_W-1:0] PROTO_UDP      = 8'd17;

    typedef enum logic [1:0] {
        OP_PACKET  = 2'd0,
        OP_BLOCK   = 2'd1,
        OP_UNBLOCK = 2'd2,
        OP_CLEAR   = 2'd3
    } sbf_op_t;

    typedef struct packed {
        sbf_op_t              cmd;
        logic [ADDR_W-1:0]    address;
        logic                 header_present;
        logic [PROTO_W-1:0]   ip_protocol;
        logic [PORT_W-1:0]    dest_port;
    } sbf_in_t;

    typedef struct packed {
        logic                 verdict;
        logic [COUNT_W-1:0]   total_count;
        logic [COUNT_W-1:0]   dropped_count;
        logic [COUNT_W-1:0]   tcp_count;
        logic [COUNT_W-1:0]   udp_count;
        logic [COUNT_W-1:0]   api_count;
        logic [ENTRIES_W-1:0] entries_used;
    } sbf_out_t;

    typedef struct packed {
        logic capture;
        logic commit;
    } sbf_cmd_t;

endpackage

@@ hdl/source_blocklist_packet_filter_core.sv @@
// Top level of the source address blocklist filter with packet counters.
//
//   Channel   Direction  Handshake              Payload
//   in        input      in_valid / in_stall    in_item (sbf_in_t)
//   out       output     out_valid / out_stall  out_item (sbf_out_t)
//   cfg       input      cfg_we                 cfg_wdata (API port)
//
// A transaction is captured into the item register, compared against every table
// entry in parallel into the match register, and then committed; the commit may
// accept the following transaction. Reset empties the table, clears the counters
// and loads port 8420.
// While a result is stalled in the output register the commit waits.
`include "source_blocklist_packet_filter_core_macros.svh"

module source_blocklist_packet_filter_core (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  sbf_pkg::sbf_in_t           in_item,
    output logic                       out_valid,
    input  logic                       out_stall,
    output sbf_pkg::sbf_out_t          out_item,
    input  logic                       cfg_we,
    input  logic [sbf_pkg::PORT_W-1:0] cfg_wdata
);
    import sbf_pkg::*;

    sbf_cmd_t ctrl_cmd;

    sbf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (ctrl_cmd)
    );

    sbf_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (ctrl_cmd),
        .in_item   (in_item),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .out_item  (out_item)
    );

    `SBF_ASSERT_IMP(a_commit_free, ctrl_cmd.commit, !(out_valid && out_stall), "commit over a stalled result")
    `SBF_ASSERT_NXT(a_capture_gap, ctrl_cmd.capture, !ctrl_cmd.capture, "transactions captured on adjacent edges")
    `SBF_ASSERT_IMP(a_api_le_tcp, out_valid, out_item.api_count <= out_item.tcp_count, "API count above TCP count")
    `SBF_ASSERT(a_entries_max, int'(out_item.entries_used) <= TABLE_DEPTH || !out_valid, "table count above depth")

endmodule

@@ hdl/sbf_ctrl.sv @@
// Controller state machine sequencing capture, compare and commit.
module sbf_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    output logic             out_valid,
    input  logic             out_stall,
    output sbf_pkg::sbf_cmd_t cmd
);
    import sbf_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MATCH,
        S_APPLY
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   commit;
    logic   capture;

    always_comb
    begin
        commit   = (state_reg == S_APPLY) && !(out_valid_reg && out_stall);
        in_stall = !((state_reg == S_IDLE) || commit);
        capture  = in_valid && !in_stall;

        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (capture)
                begin
                    state_next = S_MATCH;
                end
            end
            S_MATCH:
            begin
                state_next = S_APPLY;
            end
            S_APPLY:
            begin
                if (commit)
                begin
                    state_next = capture ? S_MATCH : S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (commit)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && out_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign cmd.capture = capture;
    assign cmd.commit  = commit;

endmodule

@@ hdl/sbf_datapath.sv @@
// Datapath holding the address table, the counters and the result register.
module sbf_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  sbf_pkg::sbf_cmd_t             cmd,
    input  sbf_pkg::sbf_in_t              in_item,
    input  logic                          cfg_we,
    input  logic [sbf_pkg::PORT_W-1:0]    cfg_wdata,
    output sbf_pkg::sbf_out_t             out_item
);
    import sbf_pkg::*;

    logic [ADDR_W-1:0]      block_mem [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] match_reg;
    logic [ADDR_W-1:0]      last_reg;
    sbf_in_t                item_reg;
    sbf_out_t               out_reg;
    sbf_out_t               out_next;
    logic [PORT_W-1:0]      api_port_reg;

    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic [COUNT_W-1:0] total_reg;
    logic [COUNT_W-1:0] total_next;
    logic [COUNT_W-1:0] dropped_reg;
    logic [COUNT_W-1:0] dropped_next;
    logic [COUNT_W-1:0] tcp_reg;
    logic [COUNT_W-1:0] tcp_next;
    logic [COUNT_W-1:0] udp_reg;
    logic [COUNT_W-1:0] udp_next;
    logic [COUNT_W-1:0] api_reg;
    logic [COUNT_W-1:0] api_next;

    logic              hit;
    logic              verdict;
    logic [IDX_W-1:0]  slot;
    logic [IDX_W-1:0]  last_idx;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_idx;
    logic [ADDR_W-1:0] wr_data;

    // Live entries are unique, so at most one bit of the match vector is set.
    function automatic logic [IDX_W-1:0] encode_slot(input logic [TABLE_DEPTH-1:0] vec);
        logic [IDX_W-1:0] idx;
        idx = '0;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            if (vec[i])
            begin
                idx = idx | IDX_W'(i);
            end
        end
        return idx;
    endfunction

    assign last_idx = IDX_W'(count_reg - CNT_W'(1));

    always_comb
    begin
        hit          = |match_reg;
        slot         = encode_slot(match_reg);
        verdict      = 1'b0;
        wr_en        = 1'b0;
        wr_idx       = slot;
        wr_data      = last_reg;
        count_next   = count_reg;
        total_next   = total_reg;
        dropped_next = dropped_reg;
        tcp_next     = tcp_reg;
        udp_next     = udp_reg;
        api_next     = api_reg;

        unique case (item_reg.cmd)
            OP_PACKET:
            begin
                if (item_reg.header_present)
                begin
                    total_next = total_reg + COUNT_W'(1);
                    if (hit)
                    begin
                        dropped_next = dropped_reg + COUNT_W'(1);
                        verdict      = 1'b1;
                    end
                    else if (item_reg.ip_protocol == PROTO_TCP)
                    begin
                        tcp_next = tcp_reg + COUNT_W'(1);
                        if (item_reg.dest_port == api_port_reg)
                        begin
                            api_next = api_reg + COUNT_W'(1);
                        end
                    end
                    else if (item_reg.ip_protocol == PROTO_UDP)
                    begin
                        udp_next = udp_reg + COUNT_W'(1);
                    end
                end
            end
            OP_BLOCK:
            begin
                if ((count_reg < CNT_W'(TABLE_DEPTH)) && !hit)
                begin
                    wr_en      = cmd.commit;
                    wr_idx     = IDX_W'(count_reg);
                    wr_data    = item_reg.address;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            OP_UNBLOCK:
            begin
                if (hit)
                begin
                    wr_en      = cmd.commit;
                    wr_idx     = slot;
                    wr_data    = last_reg;
                    count_next = count_reg - CNT_W'(1);
                end
            end
            OP_CLEAR:
            begin
                total_next   = '0;
                dropped_next = '0;
                tcp_next     = '0;
                udp_next     = '0;
                api_next     = '0;
            end
        endcase

        out_next.verdict       = verdict;
        out_next.total_count   = total_next;
        out_next.dropped_count = dropped_next;
        out_next.tcp_count     = tcp_next;
        out_next.udp_count     = udp_next;
        out_next.api_count     = api_next;
        out_next.entries_used  = ENTRIES_W'(count_next);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            item_reg <= in_item;
        end
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            match_reg[i] <= (block_mem[i] == item_reg.address) && (CNT_W'(i) < count_reg);
        end
        last_reg <= block_mem[last_idx];
        if (wr_en)
        begin
            block_mem[wr_idx] <= wr_data;
        end
        if (cmd.commit)
        begin
            out_reg <= out_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            api_port_reg <= API_PORT_RESET;
            count_reg    <= '0;
            total_reg    <= '0;
            dropped_reg  <= '0;
            tcp_reg      <= '0;
            udp_reg      <= '0;
            api_reg      <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                api_port_reg <= cfg_wdata;
            end
            if (cmd.commit)
            begin
                count_reg   <= count_next;
                total_reg   <= total_next;
                dropped_reg <= dropped_next;
                tcp_reg     <= tcp_next;
                udp_reg     <= udp_next;
                api_reg     <= api_next;
            end
        end
    end

    assign out_item = out_reg;

endmodule

@@ test/source_blocklist_packet_filter_core_tb.sv @@
// Self-checking testbench for the source address blocklist filter core.
`timescale 1ns / 100ps

module source_blocklist_packet_filter_core_tb;
    import sbf_pkg::*;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     in_valid = 1'b0;
    logic     in_stall;
    sbf_in_t  in_item = '0;
    logic     out_valid;
    logic     out_stall = 1'b0;
    sbf_out_t out_item;
    logic     cfg_we = 1'b0;
    logic [PORT_W-1:0] cfg_wdata = '0;

    logic [ADDR_W-1:0]  blocked_addr [TABLE_DEPTH];
    int                 blocked_used = 0;
    logic [COUNT_W-1:0] tally_total = '0;
    logic [COUNT_W-1:0] tally_dropped = '0;
    logic [COUNT_W-1:0] tally_tcp = '0;
    logic [COUNT_W-1:0] tally_udp = '0;
    logic [COUNT_W-1:0] tally_api = '0;
    logic [PORT_W-1:0]  watched_port = API_PORT_RESET;

    sbf_out_t expected_tallies [$];
    sbf_out_t awaited;
    int       mismatch_count = 0;
    bit       quiet = 1'b0;
    int       hold_asks = 0;
    int       hold_seen = 0;
    int       hold_left = 0;
    logic [ADDR_W-1:0] addr_pool [96];

    source_blocklist_packet_filter_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always #5 clk = ~clk;

    function automatic int find_blocked(input logic [ADDR_W-1:0] addr);
        for (int i = 0; i < blocked_used; i++)
        begin
            if (blocked_addr[i] == addr)
                return i;
        end
        return blocked_used;
    endfunction

    function automatic sbf_out_t apply_to_blocklist(input sbf_in_t item);
        sbf_out_t res;
        int       slot;
        res = '0;
        slot = find_blocked(item.address);
        case (item.cmd)
            OP_PACKET:
            begin
                if (item.header_present)
                begin
                    tally_total++;
                    if (slot < blocked_used)
                    begin
                        tally_dropped++;
                        res.verdict = 1'b1;
                    end
                    else if (item.ip_protocol == PROTO_TCP)
                    begin
                        tally_tcp++;
                        if (item.dest_port == watched_port)
                            tally_api++;
                    end
                    else if (item.ip_protocol == PROTO_UDP)
                        tally_udp++;
                end
            end
            OP_BLOCK:
            begin
                if (blocked_used < TABLE_DEPTH && slot == blocked_used)
                begin
                    blocked_addr[blocked_used] = item.address;
                    blocked_used++;
                end
            end
            OP_UNBLOCK:
            begin
                if (slot < blocked_used)
                begin
                    blocked_used--;
                    blocked_addr[slot] = blocked_addr[blocked_used];
                end
            end
            default:
            begin
                tally_total = '0;
                tally_dropped = '0;
                tally_tcp = '0;
                tally_udp = '0;
                tally_api = '0;
            end
        endcase
        res.total_count = tally_total;
        res.dropped_count = tally_dropped;
        res.tcp_count = tally_tcp;
        res.udp_count = tally_udp;
        res.api_count = tally_api;
        res.entries_used = blocked_used[ENTRIES_W-1:0];
        return res;
    endfunction

    function automatic sbf_in_t make_item(input sbf_op_t cmd, input logic [ADDR_W-1:0] addr,
                                          input logic hdr, input logic [PROTO_W-1:0] proto,
                                          input logic [PORT_W-1:0] port);
        sbf_in_t item;
        item.cmd = cmd;
        item.address = addr;
        item.header_present = hdr;
        item.ip_protocol = proto;
        item.dest_port = port;
        return item;
    endfunction

    function automatic sbf_in_t random_item(input int pool_size, input int block_weight);
        sbf_in_t item;
        int      pick;
        pick = $urandom_range(99);
        if (pick < block_weight)
            item.cmd = OP_BLOCK;
        else if (pick < block_weight + 12)
            item.cmd = OP_UNBLOCK;
        else if (pick < block_weight + 14)
            item.cmd = OP_CLEAR;
        else
            item.cmd = OP_PACKET;
        if ($urandom_range(99) < 85)
            item.address = addr_pool[$urandom_range(pool_size - 1)];
        else
            item.address = $urandom;
        item.header_present = ($urandom_range(99) < 90);
        pick = $urandom_range(99);
        if (pick < 40)
            item.ip_protocol = PROTO_TCP;
        else if (pick < 75)
            item.ip_protocol = PROTO_UDP;
        else
            item.ip_protocol = PROTO_W'($urandom_range(255));
        if ($urandom_range(99) < 30)
            item.dest_port = watched_port;
        else
            item.dest_port = PORT_W'($urandom_range(16'hFFFF));
        return item;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t mismatch: %s", $realtime, msg);
        mismatch_count++;
    endtask

    task automatic compare_field(input string name, input logic [COUNT_W-1:0] got,
                                 input logic [COUNT_W-1:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
    endtask

    task automatic send_item(input sbf_in_t item);
        if (!quiet && $urandom_range(99) < 8)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item <= item;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        expected_tallies.push_back(apply_to_blocklist(item));
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_tallies.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_api_port(input logic [PORT_W-1:0] port);
        wait_drained();
        cfg_we <= 1'b1;
        cfg_wdata <= port;
        @(posedge clk);
        watched_port = port;
        cfg_we <= 1'b0;
    endtask

    task automatic test_directed_cases();
        send_item(make_item(OP_PACKET, 32'h0, 1'b0, PROTO_TCP, API_PORT_RESET));
        send_item(make_item(OP_PACKET, 32'h0, 1'b1, PROTO_TCP, API_PORT_RESET));
        send_item(make_item(OP_PACKET, 32'hFFFF_FFFF, 1'b1, PROTO_TCP, 16'h0000));
        send_item(make_item(OP_PACKET, 32'hA5A5_5A5A, 1'b1, PROTO_TCP, 16'hFFFF));
        send_item(make_item(OP_PACKET, 32'h5A5A_A5A5, 1'b1, PROTO_UDP, 16'hFFFF));
        send_item(make_item(OP_PACKET, 32'h0102_0304, 1'b1, 8'h00, API_PORT_RESET));
        send_item(make_item(OP_PACKET, 32'h0102_0304, 1'b1, 8'hFF, API_PORT_RESET));
        send_item(make_item(OP_BLOCK, 32'hFFFF_FFFF, 1'b0, 8'h00, 16'h0000));
        send_item(make_item(OP_BLOCK, 32'hFFFF_FFFF, 1'b1, 8'hFF, 16'hFFFF));
        send_item(make_item(OP_PACKET, 32'hFFFF_FFFF, 1'b1, PROTO_TCP, API_PORT_RESET));
        send_item(make_item(OP_PACKET, 32'hFFFF_FFFF, 1'b0, PROTO_TCP, API_PORT_RESET));
        send_item(make_item(OP_BLOCK, 32'h0, 1'b0, 8'h00, 16'h0000));
        send_item(make_item(OP_PACKET, 32'h0, 1'b1, PROTO_UDP, 16'h1234));
        send_item(make_item(OP_UNBLOCK, 32'h1234_5678, 1'b1, PROTO_TCP, 16'h0000));
        send_item(make_item(OP_UNBLOCK, 32'hFFFF_FFFF, 1'b0, 8'h00, 16'h0000));
        send_item(make_item(OP_PACKET, 32'hFFFF_FFFF, 1'b1, PROTO_UDP, 16'h0000));
        send_item(make_item(OP_PACKET, 32'h0, 1'b1, PROTO_TCP, API_PORT_RESET));
        send_item(make_item(OP_CLEAR, 32'h0, 1'b1, PROTO_TCP, API_PORT_RESET));
        send_item(make_item(OP_PACKET, 32'h0, 1'b1, PROTO_TCP, API_PORT_RESET));
        send_item(make_item(OP_UNBLOCK, 32'h0, 1'b1, PROTO_UDP, 16'hFFFF));
        send_item(make_item(OP_UNBLOCK, 32'h0, 1'b0, 8'h00, 16'h0000));
        send_item(make_item(OP_PACKET, 32'h0, 1'b1, PROTO_TCP, API_PORT_RESET));
        wait_drained();
    endtask

    task automatic test_table_full();
        for (int i = 0; i < TABLE_DEPTH; i++)
            send_item(make_item(OP_BLOCK, 32'h0A00_0000 + i, 1'b0, 8'h00, 16'h0000));
        send_item(make_item(OP_BLOCK, 32'hC0A8_0001, 1'b0, 8'h00, 16'h0000));
        send_item(make_item(OP_PACKET, 32'hC0A8_0001, 1'b1, PROTO_TCP, watched_port));
        send_item(make_item(OP_PACKET, 32'h0A00_003F, 1'b1, PROTO_TCP, watched_port));
        send_item(make_item(OP_UNBLOCK, 32'h0A00_0005, 1'b0, 8'h00, 16'h0000));
        send_item(make_item(OP_PACKET, 32'h0A00_003F, 1'b1, PROTO_UDP, 16'h0000));
        send_item(make_item(OP_PACKET, 32'h0A00_0005, 1'b1, PROTO_UDP, 16'h0000));
        send_item(make_item(OP_BLOCK, 32'hC0A8_0001, 1'b0, 8'h00, 16'h0000));
        send_item(make_item(OP_PACKET, 32'hC0A8_0001, 1'b1, PROTO_TCP, watched_port));
        for (int i = TABLE_DEPTH - 1; i >= 0; i--)
            send_item(make_item(OP_UNBLOCK, 32'h0A00_0000 + i, 1'b0, 8'h00, 16'h0000));
        send_item(make_item(OP_UNBLOCK, 32'hC0A8_0001, 1'b0, 8'h00, 16'h0000));
        wait_drained();
    endtask

    task automatic test_api_port_config();
        logic [PORT_W-1:0] ports [5];
        ports[0] = 16'h0000;
        ports[1] = 16'hFFFF;
        ports[2] = 16'h5555;
        ports[3] = PORT_W'($urandom_range(16'hFFFF));
        ports[4] = API_PORT_RESET;
        for (int i = 0; i < 5; i++)
        begin
            write_api_port(ports[i]);
            send_item(make_item(OP_PACKET, $urandom, 1'b1, PROTO_TCP, ports[i]));
            send_item(make_item(OP_PACKET, $urandom, 1'b1, PROTO_TCP, ports[i] + 1'b1));
            send_item(make_item(OP_PACKET, $urandom, 1'b1, PROTO_TCP, ports[i] - 1'b1));
            send_item(make_item(OP_PACKET, $urandom, 1'b1, PROTO_UDP, ports[i]));
        end
        wait_drained();
    endtask

    task automatic test_backpressure();
        hold_asks++;
        for (int i = 0; i < 40; i++)
            send_item(random_item(16, 10));
        wait_drained();
    endtask

    task automatic test_random_traffic();
        for (int i = 0; i < 430; i++)
            send_item(random_item(16, 10));
        write_api_port(PORT_W'($urandom_range(16'hFFFF)));
        quiet = 1'b1;
        for (int i = 0; i < 300; i++)
            send_item(random_item(16, 10));
        quiet = 1'b0;
        write_api_port(16'hFFFF);
        for (int i = 0; i < 500; i++)
            send_item(random_item(96, 30));
        write_api_port(16'h0000);
        for (int i = 0; i < 400; i++)
            send_item(random_item(8, 10));
        wait_drained();
    endtask

    always @(posedge clk)
    begin
        if (hold_asks != hold_seen)
        begin
            hold_seen <= hold_asks;
            hold_left <= 250;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_tallies.size() == 0)
                report_mismatch("result with no transaction outstanding");
            else
            begin
                awaited = expected_tallies.pop_front();
                compare_field("verdict", COUNT_W'(out_item.verdict),
                              COUNT_W'(awaited.verdict));
                compare_field("total_count", out_item.total_count, awaited.total_count);
                compare_field("dropped_count", out_item.dropped_count, awaited.dropped_count);
                compare_field("tcp_count", out_item.tcp_count, awaited.tcp_count);
                compare_field("udp_count", out_item.udp_count, awaited.udp_count);
                compare_field("api_count", out_item.api_count, awaited.api_count);
                compare_field("entries_used", COUNT_W'(out_item.entries_used),
                              COUNT_W'(awaited.entries_used));
            end
        end
        out_stall <= (hold_left != 0) || (!quiet && $urandom_range(99) < 8);
    end

    initial
    begin
        for (int i = 0; i < 96; i++)
            addr_pool[i] = $urandom;
        addr_pool[0] = 32'h0000_0000;
        addr_pool[1] = 32'hFFFF_FFFF;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_cases();
        test_table_full();
        test_api_port_config();
        test_backpressure();
        test_random_traffic();
        repeat (10) @(posedge clk);
        if (mismatch_count == 0 && expected_tallies.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        #3000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+hdl
hdl/sbf_pkg.sv
hdl/sbf_ctrl.sv
hdl/sbf_datapath.sv
hdl/source_blocklist_packet_filter_core.sv
test/source_blocklist_packet_filter_core_tb.sv
